@@ src/oat_pkg.sv @@
// Shared types and constants for the ordered array table.
`default_nettype none
package oat_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int POS_W        = 4;
    localparam int DATA_W       = 32;
    localparam int OUT_CNT_W    = 5;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_RANGE    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Broadcast from the control to every cell during an execute cycle.
    typedef struct packed {
        logic              do_insert;
        logic              do_update;
        logic              do_delete;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] new_value;
    } t_cell_ctl;

endpackage
`default_nettype wire

@@ src/oat_cell.sv @@
// One list slot: holds an entry, compares it, and shifts with its neighbors.
`default_nettype none
module oat_cell
    import oat_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [CNT_W-1:0]  i_count,
    input  wire logic [DATA_W-1:0] i_lower,   // entry of slot IDX-1
    input  wire logic [DATA_W-1:0] i_upper,   // entry of slot IDX+1
    input  wire logic              i_before,  // a match sits in a lower slot
    output logic      [DATA_W-1:0] o_entry,
    output logic                   o_match
);

    localparam int CMPW = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;
    logic [CMPW-1:0]   idx_c;
    logic [CMPW-1:0]   idx_p1_c;
    logic [CMPW-1:0]   cnt_c;
    logic [CMPW-1:0]   pos_c;
    logic              in_list;

    assign idx_c    = CMPW'(IDX);
    assign idx_p1_c = CMPW'(IDX + 1);
    assign cnt_c    = CMPW'(i_count);
    assign pos_c    = CMPW'(i_ctl.pos);
    assign in_list  = idx_c < cnt_c;
    assign o_match  = in_list && (r_entry == i_ctl.value);
    assign o_entry  = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.do_insert) begin
            if (idx_c == pos_c) begin
                n_entry = i_ctl.value;
            end else if (idx_c > pos_c && idx_c <= cnt_c) begin
                n_entry = i_lower;
            end
        end else if (i_ctl.do_update) begin
            if (o_match && !i_before) begin
                n_entry = i_ctl.new_value;
            end
        end else if (i_ctl.do_delete) begin
            // slots from the first match up to count-2 pull from above
            if ((i_before || o_match) && idx_p1_c < cnt_c) begin
                n_entry = i_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire

@@ src/oat_scan.sv @@
// Log-depth prefix OR of the per-slot match flags.
`default_nettype none
module oat_scan #(
    parameter int N = 16
) (
    input  wire logic [N-1:0] i_match,
    output logic      [N-1:0] o_before,
    output logic              o_any
);

    localparam int LVLS = $clog2(N);

    logic [N-1:0] lvl [0:LVLS];

    assign lvl[0] = i_match;

    for (genvar g = 0; g < LVLS; g++) begin : g_lvl
        for (genvar i = 0; i < N; i++) begin : g_bit
            if (i >= (1 << g)) begin : g_or
                assign lvl[g+1][i] = lvl[g][i] | lvl[g][i - (1 << g)];
            end else begin : g_pass
                assign lvl[g+1][i] = lvl[g][i];
            end
        end
    end

    assign o_before = {lvl[LVLS][N-2:0], 1'b0};
    assign o_any    = lvl[LVLS][N-1];

endmodule
`default_nettype wire

@@ src/ordered_array_table.sv @@
// Top level of the ordered array table: control, cell row and result register.
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one operation per transfer:
//   kind (insert, update by value, delete by value, read by position), position,
//   value and new_value. Output channel (o_out_valid / i_out_ready) carries one
//   result per operation: status, read_data and entry_count after the operation.
// Timing
//   A transfer lands in an operation register; when the result register is
//   free or being emptied, every cell compares and shifts in parallel, the
//   result is written to the output register and o_out_valid is set.
//   Throughput is one operation per cycle while results are taken without
//   stalls: the execute step is one combinational path through the per-cell
//   compare, the log-depth prefix OR over the match flags and the neighbor
//   shift mux.
// Stall
//   While a result waits in the output register, the pending operation holds
//   and o_in_ready drops; nothing is lost or repeated.
// Reset
//   Synchronous, active low. Clears the entry count and both valid flags.
//   Entry contents are not cleared; slots beyond the count are never read.
`default_nettype none
module ordered_array_table
    import oat_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [1:0]              i_kind,
    input  wire logic [POS_W-1:0]        i_position,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic signed [DATA_W-1:0] i_new_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [1:0]                   o_status,
    output logic signed [DATA_W-1:0]     o_read_data,
    output logic [OUT_CNT_W-1:0]         o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMPW  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int RD_N  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

    // operation register
    logic              r_op_valid;
    t_kind             r_kind;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] r_new_value;

    // list length
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    // result register
    logic                 r_out_valid;
    t_status              r_status;
    logic [DATA_W-1:0]    r_read_data;
    logic [OUT_CNT_W-1:0] r_entry_count;

    logic              in_xfer;
    logic              exec;
    logic              full;
    logic              pos_past;
    logic              pos_in;
    t_status           n_status;
    logic [DATA_W-1:0] n_read_data;
    logic [DATA_W-1:0] rd_mux;
    t_cell_ctl         ctl;

    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] prior;
    logic                any_match;
    logic [DATA_W-1:0]   entry [0:CAPACITY-1];

    // execute when an operation is pending and the result slot is free or being emptied
    assign exec       = r_op_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_op_valid || exec;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign full     = r_count == CNT_W'(CAPACITY);
    assign pos_past = CMPW'(r_pos) > CMPW'(r_count);
    assign pos_in   = CMPW'(r_pos) < CMPW'(r_count);

    always_comb begin
        ctl.do_insert = exec && r_kind == KIND_INSERT && !full && !pos_past;
        ctl.do_update = exec && r_kind == KIND_UPDATE && any_match;
        ctl.do_delete = exec && r_kind == KIND_DELETE && any_match;
        ctl.pos       = r_pos;
        ctl.value     = r_value;
        ctl.new_value = r_new_value;
    end

    // cell row: each slot sees its two neighbors
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;
        if (i == 0) begin : g_lo_edge
            assign lower = r_value;
        end else begin : g_lo
            assign lower = entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_hi_edge
            assign upper = '0;
        end else begin : g_hi
            assign upper = entry[i+1];
        end
        oat_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_count  (r_count),
            .i_lower  (lower),
            .i_upper  (upper),
            .i_before (prior[i]),
            .o_entry  (entry[i]),
            .o_match  (match[i])
        );
    end

    oat_scan #(
        .N (CAPACITY)
    ) u_scan (
        .i_match  (match),
        .o_before (prior),
        .o_any    (any_match)
    );

    // read port reaches only the slots a 4-bit position can name
    always_comb begin
        rd_mux = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (r_pos == POS_W'(i)) begin
                rd_mux = entry[i];
            end
        end
    end

    always_comb begin
        n_status    = ST_OK;
        n_read_data = '0;
        n_count     = r_count;
        case (r_kind)
            KIND_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (pos_past) begin
                    n_status = ST_RANGE;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            KIND_UPDATE: begin
                if (!any_match) begin
                    n_status = ST_NOTFOUND;
                end
            end
            KIND_DELETE: begin
                if (!any_match) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            KIND_READ: begin
                if (pos_in) begin
                    n_read_data = rd_mux;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (in_xfer) begin
                r_op_valid <= 1'b1;
            end else if (exec) begin
                r_op_valid <= 1'b0;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind      <= t_kind'(i_kind);
            r_pos       <= i_position;
            r_value     <= i_value;
            r_new_value <= i_new_value;
        end
        if (exec) begin
            r_status      <= n_status;
            r_read_data   <= n_read_data;
            r_entry_count <= OUT_CNT_W'(n_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_read_data   = r_read_data;
    assign o_entry_count = r_entry_count;

    // list never grows past capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_count) <= CMPW'(CAPACITY))
        else $error("entry count above capacity");

    // a successful delete shrinks the list by exactly one
    a_del_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.do_delete |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("delete did not decrement count");

    // reads and updates leave the count alone
    a_keep_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && (r_kind == KIND_READ || r_kind == KIND_UPDATE) |=> $stable(r_count))
        else $error("count changed on read or update");

    // a pending operation that cannot execute blocks new transfers
    a_hold_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op_valid && !exec |-> !o_in_ready)
        else $error("transfer taken over a pending operation");

endmodule
`default_nettype wire

@@ tb/ordered_array_table_checker.sv @@
// Transfer monitor, list predictor and result scoreboard for the ordered array table.
module ordered_array_table_checker
    import oat_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic                     i_in_ready,
    input  wire logic [1:0]               i_kind,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic [DATA_W-1:0]        i_value,
    input  wire logic [DATA_W-1:0]        i_new_value,
    input  wire logic                     i_out_valid,
    input  wire logic                     i_out_ready,
    input  wire logic [1:0]               i_status,
    input  wire logic [DATA_W-1:0]        i_read_data,
    input  wire logic [OUT_CNT_W-1:0]     i_entry_count,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);

    typedef struct packed {
        t_status                status;
        logic [DATA_W-1:0]      read_data;
        logic [OUT_CNT_W-1:0]   entry_count;
    } t_list_result;

    // Shadow copy of the list
    logic [DATA_W-1:0] list_mem [CAPACITY];
    int                list_len;

    t_list_result      awaited_results [$];

    // Applies one operation to the shadow list and returns what the block must report.
    function automatic t_list_result apply_list_op(
        input t_kind             kind,
        input logic [POS_W-1:0]  pos,
        input logic [DATA_W-1:0] val,
        input logic [DATA_W-1:0] nval
    );
        t_list_result res;
        int           hit;
        res.status    = ST_OK;
        res.read_data = '0;
        hit           = list_len;
        // first match wins
        for (int k = list_len - 1; k >= 0; k--) begin
            if (list_mem[k] == val) hit = k;
        end
        case (kind)
            KIND_INSERT: begin
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (int'(pos) > list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int k = list_len; k > int'(pos); k--) list_mem[k] = list_mem[k-1];
                    list_mem[pos] = val;
                    list_len++;
                end
            end
            KIND_UPDATE: begin
                if (hit >= list_len) res.status = ST_NOTFOUND;
                else list_mem[hit] = nval;
            end
            KIND_DELETE: begin
                if (hit >= list_len) begin
                    res.status = ST_NOTFOUND;
                end else begin
                    for (int k = hit; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            end
            default: begin
                if (int'(pos) < list_len) res.read_data = list_mem[pos];
                else res.status = ST_RANGE;
            end
        endcase
        res.entry_count = list_len[OUT_CNT_W-1:0];
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        list_len     = 0;
    end

    assign o_pending = awaited_results.size();

    always @(posedge i_clk) begin
        t_list_result exp_res;
        if (!i_rst_n) begin
            list_len = 0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with nothing awaited: status %0d data %h count %0d",
                             $time, i_status, i_read_data, i_entry_count);
                    o_fail_count++;
                end else begin
                    exp_res = awaited_results.pop_front();
                    o_checked++;
                    if (i_status !== exp_res.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_res.status, i_status);
                        o_fail_count++;
                    end
                    if (i_read_data !== exp_res.read_data) begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, exp_res.read_data, i_read_data);
                        o_fail_count++;
                    end
                    if (i_entry_count !== exp_res.entry_count) begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, exp_res.entry_count, i_entry_count);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                awaited_results.push_back(apply_list_op(t_kind'(i_kind), i_position,
                                                        i_value, i_new_value));
            end
        end
    end

endmodule

@@ tb/ordered_array_table_test.sv @@
// Top of the ordered array table test: clock, reset, stimulus and verdict.
module ordered_array_table_test;
    import oat_pkg::*;

    localparam logic [DATA_W-1:0] W_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] W_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] W_ONES = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] W_ZERO = 32'h0000_0000;
    localparam int                N_RANDOM = 800;
    localparam int                POOL_N   = 12;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    out_ready   = 1'b0;
    logic [1:0]              op_kind     = '0;
    logic [POS_W-1:0]        op_pos      = '0;
    logic [DATA_W-1:0]       op_value    = '0;
    logic [DATA_W-1:0]       op_new_val  = '0;

    wire logic               in_ready;
    wire logic               out_valid;
    wire logic [1:0]         res_status;
    wire logic [DATA_W-1:0]  res_data;
    wire logic [OUT_CNT_W-1:0] res_count;

    int                      fail_count;
    int                      pending;
    int                      checked;

    // When set, neither side inserts bubbles
    bit                      quiet = 1'b0;
    int                      kind_sent [4] = '{0, 0, 0, 0};
    // Small value pool so that update and delete actually find matches,
    // and duplicates exercise the first-match rule
    logic [DATA_W-1:0]       value_pool [POOL_N];

    always #5 i_clk = ~i_clk;

    ordered_array_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_kind        (op_kind),
        .i_position    (op_pos),
        .i_value       (op_value),
        .i_new_value   (op_new_val),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (res_status),
        .o_read_data   (res_data),
        .o_entry_count (res_count)
    );

    ordered_array_table_checker scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_kind        (op_kind),
        .i_position    (op_pos),
        .i_value       (op_value),
        .i_new_value   (op_new_val),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (res_status),
        .i_read_data   (res_data),
        .i_entry_count (res_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // Result side backpressure: out_ready is low with a chance of about 15 in a hundred, never while quiet.
    always @(negedge i_clk) begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 15);
    end

    // Watchdog: ends the test as failed if the run has not finished first.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // One operation per call. Driven at the falling edge; valid stays high
    // until the transfer happens at a rising edge. A random bubble may come first.
    task automatic send_op(
        input t_kind             k,
        input logic [POS_W-1:0]  p,
        input logic [DATA_W-1:0] v,
        input logic [DATA_W-1:0] nv
    );
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(99) < 6) begin
            gap      = $urandom_range(1, 4);
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid   = 1'b1;
        op_kind    = k;
        op_pos     = p;
        op_value   = v;
        op_new_val = nv;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        kind_sent[k]++;
    endtask

    // Hold the sender off until every awaited result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int   mode;
        int   roll;
        t_kind k;
        logic [POS_W-1:0]  p;
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] nv;

        value_pool[0] = W_MIN;
        value_pool[1] = W_MAX;
        value_pool[2] = W_ZERO;
        value_pool[3] = W_ONES;
        for (int i = 4; i < POOL_N; i++) value_pool[i] = $urandom;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty list, range and not-found rejects, append, shifting
        // insert, first-match update, deletes, reads at both ends.
        send_op(KIND_READ,   4'd0,  W_ZERO, W_ZERO);     // read on empty list
        send_op(KIND_DELETE, 4'd0,  W_MAX,  W_ZERO);     // delete, no match
        send_op(KIND_UPDATE, 4'd0,  W_ZERO, W_ONES);     // update, no match
        send_op(KIND_INSERT, 4'd1,  W_ONES, W_ZERO);     // insert past count
        send_op(KIND_INSERT, 4'd0,  W_MIN,  W_ZERO);
        send_op(KIND_INSERT, 4'd1,  W_MAX,  W_ONES);     // append at count
        send_op(KIND_INSERT, 4'd0,  W_ONES, W_ZERO);     // shift everything up
        send_op(KIND_INSERT, 4'd5,  W_ZERO, W_ZERO);     // past count again
        send_op(KIND_INSERT, 4'd1,  W_ZERO, W_MAX);      // shift in the middle
        send_op(KIND_INSERT, 4'd4,  W_MAX,  W_ZERO);     // duplicate value
        send_op(KIND_UPDATE, 4'd15, W_MAX,  32'h5A5A_5A5A); // only first MAX
        send_op(KIND_READ,   4'd3,  W_ZERO, W_ONES);
        send_op(KIND_READ,   4'd4,  W_ONES, W_ZERO);
        send_op(KIND_READ,   4'd5,  W_ZERO, W_ZERO);     // at count
        send_op(KIND_READ,   4'd15, W_ONES, W_ONES);     // top position
        send_op(KIND_DELETE, 4'd15, W_ZERO, W_ONES);     // middle delete
        send_op(KIND_DELETE, 4'd0,  W_MAX,  W_ZERO);     // last entry
        send_op(KIND_DELETE, 4'd0,  32'h1234_5678, W_ZERO);
        send_op(KIND_UPDATE, 4'd7,  W_ONES, W_ZERO);
        send_op(KIND_READ,   4'd0,  W_ZERO, W_ZERO);
        send_op(KIND_DELETE, 4'd0,  W_ZERO, W_ZERO);     // first entry
        send_op(KIND_READ,   4'd1,  W_ZERO, W_ZERO);

        drain_results();

        // Random: blocks of 100 alternate between filling the list (so full
        // gets hit repeatedly), draining it, and a balanced mix.
        for (int n = 0; n < N_RANDOM; n++) begin
            mode  = (n / 100) % 4;
            quiet = (n >= 300 && n < 450);
            roll  = $urandom_range(99);
            case (mode)
                0, 3:    k = (roll < 70) ? KIND_INSERT : (roll < 80) ? KIND_DELETE :
                             (roll < 85) ? KIND_UPDATE : KIND_READ;
                1:       k = (roll < 15) ? KIND_INSERT : (roll < 70) ? KIND_DELETE :
                             (roll < 85) ? KIND_UPDATE : KIND_READ;
                default: k = (roll < 30) ? KIND_INSERT : (roll < 55) ? KIND_DELETE :
                             (roll < 75) ? KIND_UPDATE : KIND_READ;
            endcase
            // positions lean low so inserts usually land inside the list
            p  = ($urandom_range(1) == 0) ? POS_W'($urandom_range(15))
                                          : POS_W'($urandom_range(4));
            v  = ($urandom_range(3) != 0) ? value_pool[$urandom_range(POOL_N - 1)]
                                          : DATA_W'($urandom);
            nv = ($urandom_range(1) == 0) ? value_pool[$urandom_range(POOL_N - 1)]
                                          : DATA_W'($urandom);
            send_op(k, p, v, nv);
        end
        quiet = 1'b0;

        drain_results();
        // Allow the operation and result registers to settle before the verdict
        repeat (10) @(posedge i_clk);

        $display("Sent %0d inserts, %0d updates, %0d deletes, %0d reads; %0d results checked",
                 kind_sent[KIND_INSERT], kind_sent[KIND_UPDATE],
                 kind_sent[KIND_DELETE], kind_sent[KIND_READ], checked);
        $display("Covered empty, full and past-count rejects, shifts and first-match hits");
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
